/* rtl/pqe_pkg.sv */
// Package: shared types, constants and arithmetic helpers for the quadrotor step block.
`default_nettype none
package pqe_pkg;

  localparam int unsigned GRAVITY_Q16 = 642908;

  // Angle constants, Q16.16 radians
  localparam logic signed [20:0] TWO_PI_Q  = 21'sd411775;
  localparam logic signed [20:0] PI_Q      = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_Q = 21'sd102944;

  // Angle reduction: bias of 5216 turns makes any 32-bit angle positive,
  // and floor(2^48 / two pi) gives the turn count by one multiply
  localparam logic signed [33:0] ANGLE_BIAS   = 34'sd2147818400;
  localparam logic signed [32:0] RECIP_TWO_PI = 33'sd683564997;

  localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STEPS    = 64;

  // Configuration register indexes
  localparam logic [3:0] CFG_BODY_MASS        = 4'd0;
  localparam logic [3:0] CFG_LINEAR_DRAG      = 4'd1;
  localparam logic [3:0] CFG_ROTATIONAL_DRAG  = 4'd2;
  localparam logic [3:0] CFG_PITCH_INERTIA    = 4'd3;
  localparam logic [3:0] CFG_ROTOR_ARM        = 4'd4;
  localparam logic [3:0] CFG_SPEED_LIMIT      = 4'd5;
  localparam logic [3:0] CFG_PITCH_RATE_LIMIT = 4'd6;
  localparam logic [3:0] CFG_TIME_STEP        = 4'd7;

  typedef struct packed {
    logic [30:0]        thrust_front_left;
    logic [30:0]        thrust_front_right;
    logic [30:0]        thrust_rear_left;
    logic [30:0]        thrust_rear_right;
    logic signed [31:0] wind_horizontal;
    logic signed [31:0] wind_vertical;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] pos_horizontal;
    logic signed [31:0] pos_vertical;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] vel_horizontal;
    logic signed [31:0] vel_vertical;
    logic signed [31:0] pitch_speed;
    logic signed [31:0] accel_horizontal;
    logic signed [31:0] accel_vertical;
  } result_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [30:0] value;
  } cfg_t;

  // Arctangent table, Q16.16
  function automatic logic [15:0] atan_q16(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_sym(input logic signed [65:0] v,
                                                   input logic [30:0] lim);
    logic signed [65:0] l;
    logic signed [65:0] r;
    l = $signed({35'd0, lim});
    if (v > l) r = l;
    else if (v < -l) r = -l;
    else r = v;
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/pqe_if.sv */
// Interface: valid/ready channel carrying one item of a given payload type.
`default_nettype none
interface pqe_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/pqe_div.sv */
// Shared radix-2 restoring divider: signed 64-bit dividend over positive 31-bit divisor.
`default_nettype none
module pqe_div
  import pqe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic signed [63:0] num,
  input  wire logic [30:0]        den,
  output logic                    done,
  output logic signed [64:0]      quo
);

  logic        busy;
  logic        neg;
  logic [63:0] acc;
  logic [30:0] part;
  logic [30:0] dvs;
  logic [5:0]  cnt;
  logic [31:0] trial;
  logic        fits;

  // One quotient bit per cycle
  assign trial = {part, acc[63]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= num[63];
        acc  <= num[63] ? 64'(-num) : num;
        part <= '0;
        dvs  <= den;
      end else if (busy) begin
        part <= fits ? 31'(trial - {1'b0, dvs}) : trial[30:0];
        acc  <= {acc[62:0], fits};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply sign of the dividend to the quotient
  assign quo = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

endmodule
`default_nettype wire

/* rtl/pqe_cordic.sv */
// Iterative CORDIC rotation: sine and cosine of a reduced angle, 16 steps on one shift-add unit.
`default_nettype none
module pqe_cordic
  import pqe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic signed [19:0] angle,
  input  wire logic               flip,
  output logic                    done,
  output logic signed [19:0]      sin_q,
  output logic signed [19:0]      cos_q
);

  logic               busy;
  logic               neg;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [19:0] z;
  logic [3:0]         i;
  logic signed [33:0] sx;
  logic signed [33:0] sy;
  logic signed [19:0] at;
  logic signed [33:0] xr;
  logic signed [33:0] yr;

  assign sx = x >>> i;
  assign sy = y >>> i;
  assign at = $signed({4'd0, atan_q16(i)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        i    <= '0;
        x    <= CORDIC_K_Q30;
        y    <= '0;
        z    <= angle;
        neg  <= flip;
      end else if (busy) begin
        // Rotate toward zero residual angle
        if (z >= 0) begin
          x <= x - sy;
          y <= y + sx;
          z <= z - at;
        end else begin
          x <= x + sy;
          y <= y - sx;
          z <= z + at;
        end
        i <= i + 4'd1;
        if (i == 4'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Round Q2.30 to Q16.16
  assign xr = (x + 34'sd8192) >>> 14;
  assign yr = (y + 34'sd8192) >>> 14;
  assign cos_q = neg ? -xr[19:0] : xr[19:0];
  assign sin_q = neg ? -yr[19:0] : yr[19:0];

endmodule
`default_nettype wire

/* rtl/planar_quadrotor_euler_step.sv */
// Top level: planar quadrotor semi-implicit Euler step, sequencer around shared units.
// Each item is worked through in turn: a sequencer runs the item through one shared
// 34x33 multiplier, a radix-2 divider (four divisions: thrust over mass, two drag
// terms, pitch acceleration) and a 16-step CORDIC. The pitch is reduced modulo two pi
// by a reciprocal multiply on the shared multiplier in the ST_MOD and ST_RED states.
// The tick channel is ready only while the sequencer is idle; the result register is
// taken independently, and a finished item waits only if the previous result is unread.
// Configuration writes are taken at any time and must happen while idle.
`default_nettype none
module planar_quadrotor_euler_step
  import pqe_pkg::*;
#(
  parameter int unsigned GRAVITY = GRAVITY_Q16
)(
  input  wire logic clk,
  input  wire logic rst,
  pqe_if.sink       tick,
  pqe_if.source     result,
  pqe_if.sink       cfg
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_MOD  = 5'd1;
  localparam logic [4:0] ST_COR  = 5'd2;
  localparam logic [4:0] ST_TRQ  = 5'd3;
  localparam logic [4:0] ST_TPM  = 5'd4;
  localparam logic [4:0] ST_DXM  = 5'd5;
  localparam logic [4:0] ST_DX   = 5'd6;
  localparam logic [4:0] ST_DZM  = 5'd7;
  localparam logic [4:0] ST_DZ   = 5'd8;
  localparam logic [4:0] ST_PM   = 5'd9;
  localparam logic [4:0] ST_PA   = 5'd10;
  localparam logic [4:0] ST_AX   = 5'd11;
  localparam logic [4:0] ST_AZ   = 5'd12;
  localparam logic [4:0] ST_VX   = 5'd13;
  localparam logic [4:0] ST_VZ   = 5'd14;
  localparam logic [4:0] ST_VR   = 5'd15;
  localparam logic [4:0] ST_PX   = 5'd16;
  localparam logic [4:0] ST_PZ   = 5'd17;
  localparam logic [4:0] ST_PR   = 5'd18;
  localparam logic [4:0] ST_OUT  = 5'd19;
  localparam logic [4:0] ST_RED  = 5'd20;
  localparam logic [4:0] ST_ANG  = 5'd21;

  logic [4:0] state;

  // Configuration registers
  logic [30:0] mass, ldrag, rdrag, inertia, arm, vlim, rlim, dt;
  logic [30:0] mass_eff, inertia_eff;

  // Kinematic state
  logic signed [31:0] xpos, zpos, att, xv, zv, rate;

  // Per-item working registers
  logic signed [31:0] wx, wz;
  logic signed [33:0] diff;
  logic [32:0]        total;
  logic signed [31:0] torque, tpm, dx, dz, pacc, ax, az;
  logic signed [19:0] sn, cs;
  logic [18:0]        red;

  // Shared multiplier
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod, prod_sh;

  // Divider and CORDIC hookup
  logic               div_go, div_done;
  logic signed [63:0] div_num;
  logic [30:0]        div_den;
  logic signed [64:0] div_quo;
  logic signed [31:0] quo_sat;
  logic               cor_go, cor_done, cor_flip;
  logic signed [19:0] cor_angle, cor_sin, cor_cos;
  logic signed [20:0] r1, r2;

  // Angle reduction
  logic [33:0] red_u, red_qd, red_rem0, red_rem1;
  logic [14:0] red_q;

  logic tick_take;

  assign mass_eff    = (mass == '0) ? 31'd1 : mass;
  assign inertia_eff = (inertia == '0) ? 31'd1 : inertia;

  assign tick.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign tick_take  = tick.valid && tick.ready;

  // Store configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      mass    <= 31'd65536;
      ldrag   <= 31'd0;
      rdrag   <= 31'd0;
      inertia <= 31'd65536;
      arm     <= 31'd65536;
      vlim    <= 31'd655360;
      rlim    <= 31'd411775;
      dt      <= 31'd655;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        CFG_BODY_MASS:        mass    <= cfg.data.value;
        CFG_LINEAR_DRAG:      ldrag   <= cfg.data.value;
        CFG_ROTATIONAL_DRAG:  rdrag   <= cfg.data.value;
        CFG_PITCH_INERTIA:    inertia <= cfg.data.value;
        CFG_ROTOR_ARM:        arm     <= cfg.data.value;
        CFG_SPEED_LIMIT:      vlim    <= cfg.data.value;
        CFG_PITCH_RATE_LIMIT: rlim    <= cfg.data.value;
        CFG_TIME_STEP:        dt      <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // Bias the pitch positive; its floor remainder by two pi is unchanged
  assign red_u = $unsigned(34'(att) + ANGLE_BIAS);

  // Select multiplier operands; the product is consumed in the following state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MOD: begin mul_a = $signed(red_u);          mul_b = RECIP_TWO_PI; end
      ST_COR: begin mul_a = diff;                    mul_b = $signed({2'b00, arm}); end
      ST_TPM: begin mul_a = $signed({3'b000, ldrag}); mul_b = 33'(xv) - 33'(wx); end
      ST_DX:  begin mul_a = $signed({3'b000, ldrag}); mul_b = 33'(zv) - 33'(wz); end
      ST_DZ:  begin mul_a = $signed({3'b000, rdrag}); mul_b = 33'(rate); end
      ST_PA:  begin mul_a = 34'(tpm);  mul_b = 33'(sn); end
      ST_AX:  begin mul_a = 34'(tpm);  mul_b = 33'(cs); end
      ST_AZ:  begin mul_a = 34'(ax);   mul_b = $signed({2'b00, dt}); end
      ST_VX:  begin mul_a = 34'(az);   mul_b = $signed({2'b00, dt}); end
      ST_VZ:  begin mul_a = 34'(pacc); mul_b = $signed({2'b00, dt}); end
      ST_VR:  begin mul_a = 34'(xv);   mul_b = $signed({2'b00, dt}); end
      ST_PX:  begin mul_a = 34'(zv);   mul_b = $signed({2'b00, dt}); end
      ST_PZ:  begin mul_a = 34'(rate); mul_b = $signed({2'b00, dt}); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 66'(mul_a) * 66'(mul_b);
  end

  assign prod_sh = prod >>> 16;
  assign quo_sat = sat32(66'(div_quo));

  // Estimate turns from the reciprocal product, then fix the remainder once
  assign red_q    = prod[62:48];
  assign red_qd   = {19'd0, red_q} * 34'(TWO_PI_Q);
  assign red_rem0 = red_u - red_qd;
  assign red_rem1 = (red_rem0 >= 34'(TWO_PI_Q)) ? red_rem0 - 34'(TWO_PI_Q) : red_rem0;

  // Select divider operands
  always_comb begin
    div_go  = 1'b0;
    div_num = '0;
    div_den = mass_eff;
    unique case (state)
      ST_TRQ: begin
        div_go  = 1'b1;
        div_num = $signed({15'd0, total, 16'd0});
      end
      ST_DXM, ST_DZM: begin
        div_go  = 1'b1;
        div_num = $signed(prod[63:0]);
      end
      ST_PM: begin
        div_go  = 1'b1;
        div_num = (64'(torque) <<< 16) - $signed(prod[63:0]);
        div_den = inertia_eff;
      end
      default: ;
    endcase
  end

  // Fold the reduced angle into +-pi/2 with a flip flag
  always_comb begin
    r1 = $signed({2'b00, red});
    r2 = (r1 > PI_Q) ? r1 - TWO_PI_Q : r1;
    cor_flip  = 1'b0;
    cor_angle = r2[19:0];
    if (r2 > HALF_PI_Q) begin
      cor_angle = 20'(r2 - PI_Q);
      cor_flip  = 1'b1;
    end else if (r2 < -HALF_PI_Q) begin
      cor_angle = 20'(r2 + PI_Q);
      cor_flip  = 1'b1;
    end
  end

  assign cor_go = (state == ST_ANG);

  pqe_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  pqe_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .go    (cor_go),
    .angle (cor_angle),
    .flip  (cor_flip),
    .done  (cor_done),
    .sin_q (cor_sin),
    .cos_q (cor_cos)
  );

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
      xpos <= '0; zpos <= '0; att  <= '0;
      xv   <= '0; zv   <= '0; rate <= '0;
    end else begin
      if (result.valid && result.ready && state != ST_OUT) result.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (tick_take) begin
            wx    <= tick.data.wind_horizontal;
            wz    <= tick.data.wind_vertical;
            diff  <= $signed({3'b000, tick.data.thrust_rear_left})
                   + $signed({3'b000, tick.data.thrust_rear_right})
                   - $signed({3'b000, tick.data.thrust_front_left})
                   - $signed({3'b000, tick.data.thrust_front_right});
            total <= {2'b00, tick.data.thrust_front_left}
                   + {2'b00, tick.data.thrust_front_right}
                   + {2'b00, tick.data.thrust_rear_left}
                   + {2'b00, tick.data.thrust_rear_right};
            state <= ST_MOD;
          end
        end
        ST_MOD: state <= ST_RED;
        ST_RED: begin
          red   <= red_rem1[18:0];
          state <= ST_ANG;
        end
        ST_ANG: state <= ST_COR;
        ST_COR: begin
          if (cor_done) begin
            sn    <= cor_sin;
            cs    <= cor_cos;
            state <= ST_TRQ;
          end
        end
        ST_TRQ: begin
          torque <= sat32(prod_sh);
          state  <= ST_TPM;
        end
        ST_TPM: begin
          if (div_done) begin
            tpm   <= quo_sat;
            state <= ST_DXM;
          end
        end
        ST_DXM: state <= ST_DX;
        ST_DX: begin
          if (div_done) begin
            dx    <= quo_sat;
            state <= ST_DZM;
          end
        end
        ST_DZM: state <= ST_DZ;
        ST_DZ: begin
          if (div_done) begin
            dz    <= quo_sat;
            state <= ST_PM;
          end
        end
        ST_PM: state <= ST_PA;
        ST_PA: begin
          if (div_done) begin
            pacc  <= quo_sat;
            state <= ST_AX;
          end
        end
        ST_AX: begin
          ax    <= sat32(-prod_sh - 66'(dx));
          state <= ST_AZ;
        end
        ST_AZ: begin
          az    <= sat32(prod_sh - $signed({34'd0, 32'(GRAVITY)}) - 66'(dz));
          state <= ST_VX;
        end
        ST_VX: begin
          xv    <= clamp_sym(66'(xv) + prod_sh, vlim);
          state <= ST_VZ;
        end
        ST_VZ: begin
          zv    <= clamp_sym(66'(zv) + prod_sh, vlim);
          state <= ST_VR;
        end
        ST_VR: begin
          rate  <= clamp_sym(66'(rate) + prod_sh, rlim);
          state <= ST_PX;
        end
        ST_PX: begin
          xpos  <= sat32(66'(xpos) + prod_sh);
          state <= ST_PZ;
        end
        ST_PZ: begin
          zpos  <= sat32(66'(zpos) + prod_sh);
          state <= ST_PR;
        end
        ST_PR: begin
          att   <= sat32(66'(att) + prod_sh);
          state <= ST_OUT;
        end
        ST_OUT: begin
          // Hold until the result register is free
          if (!result.valid || result.ready) begin
            result.valid                 <= 1'b1;
            result.data.pos_horizontal   <= xpos;
            result.data.pos_vertical     <= zpos;
            result.data.pitch_angle      <= att;
            result.data.vel_horizontal   <= xv;
            result.data.vel_vertical     <= zv;
            result.data.pitch_speed      <= rate;
            result.data.accel_horizontal <= ax;
            result.data.accel_vertical   <= az;
            state                        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
